// ----- rtl/mfld_pkg.sv -----
// ============================================================================
// mfld_pkg
// Shared constants, codes and types of the one-bit framebuffer line drawer.
// ============================================================================
package mfld_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 200;
    localparam int PANEL_HEIGHT = 200;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int RAW_W        = $clog2((PANEL_WIDTH > PANEL_HEIGHT) ?
                                         PANEL_WIDTH : PANEL_HEIGHT);

    // request field widths
    localparam int COORD_W = 16;
    localparam int RIDX_W  = 13;

    // width of the setup arithmetic, wide enough for start and end of any line
    localparam int CW = 18;

    // request function codes
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_HLINE = 2'd1;
    localparam logic [1:0] FUNC_VLINE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // byte masks
    localparam logic [7:0] PIX_LEFT  = 8'h80;
    localparam logic [7:0] BYTE_ALL  = 8'hFF;
    localparam logic [7:0] BYTE_NONE = 8'h00;

    // one operation of the shared adder: a + (b or -b) + inc - dec
    typedef struct packed {
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic          neg_b;
        logic          inc;
        logic          dec;
    } alu_op_t;

    // one store access: wipe writes zero, otherwise read-modify-write with mask
    typedef struct packed {
        logic              req;
        logic              wipe;
        logic              set;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } store_cmd_t;

endpackage

// ----- rtl/mfld_alu.sv -----
// ============================================================================
// mfld_alu
// Shared adder of the setup sequencer: add, subtract and unit adjust.
// ============================================================================
module mfld_alu (
    input  mfld_pkg::alu_op_t        op,
    output logic [mfld_pkg::CW-1:0]  sum
);

    logic [mfld_pkg::CW-1:0] b_sel;
    logic [mfld_pkg::CW-1:0] adj;

    always_comb
    begin
        b_sel = op.neg_b ? ~op.b : op.b;
        adj   = mfld_pkg::CW'(op.neg_b) + mfld_pkg::CW'(op.inc)
              - mfld_pkg::CW'(op.dec);
        sum   = op.a + b_sel + adj;
    end

endmodule

// ----- rtl/mfld_store.sv -----
// ============================================================================
// mfld_store
// Framebuffer byte store with a two-stage read-modify-write path.
// ============================================================================
module mfld_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfld_pkg::store_cmd_t cmd,
    output logic [7:0]           rd_data
);

    logic [7:0]                  mem [mfld_pkg::STORE_BYTES];
    logic                        pend_reg;
    logic [mfld_pkg::ADDR_W-1:0] wr_addr_reg;
    logic [7:0]                  wr_mask_reg;
    logic                        wr_set_reg;
    logic [7:0]                  rd_data_reg;
    logic [7:0]                  wr_byte;

    assign wr_byte = wr_set_reg ? (rd_data_reg | wr_mask_reg)
                                : (rd_data_reg & ~wr_mask_reg);
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.req && !cmd.wipe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req && !cmd.wipe)
        begin
            rd_data_reg <= mem[cmd.addr];
            wr_addr_reg <= cmd.addr;
            wr_mask_reg <= cmd.mask;
            wr_set_reg  <= cmd.set;
        end
        // write back in the cycle after the read
        if (cmd.req && cmd.wipe)
        begin
            mem[cmd.addr] <= mfld_pkg::BYTE_NONE;
        end
        else if (pend_reg)
        begin
            mem[wr_addr_reg] <= wr_byte;
        end
    end

endmodule

// ----- rtl/mono_framebuffer_line_draw_core.sv -----
// ============================================================================
// mono_framebuffer_line_draw_core
// One-bit-per-pixel framebuffer: pixel set/clear, clipped horizontal and
// vertical lines under four rotations, and byte read-back.
// ============================================================================
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------
//   input     in_valid  / in_ready    func, x_coord, y_coord, length,
//                                     color, read_index
//   output    out_valid / out_ready   read_data, drawn
//   config    cfg_valid / cfg_ready   cfg_data (rotation, quarter turns)
//
// after reset a clearing pass zeroes the store, one byte a cycle, over
//   all STORE_BYTES (5000) bytes; requests wait, config writes are taken
// a read request passes through the READ and DONE states to its result
// a pixel or line request runs the setup states START, END, CHECK, MAP_LO,
//   MAP_HI, MAP_FIX and INDEX, mostly on the shared adder, then walks the
//   store bytes touched, one per cycle: up to ROW_BYTES (25) for a run
//   along raw x, up to PANEL_HEIGHT (200) for a run along raw y, then DONE
// a rejected or empty line skips the byte walk, from CHECK straight to DONE
// each touched byte goes through the store's single read-modify-write path
// a result waits in the output register; the next request is accepted
//   meanwhile, and only its own result stalls until the register frees
//
module mono_framebuffer_line_draw_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic signed [mfld_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mfld_pkg::COORD_W-1:0] y_coord,
    input  logic signed [mfld_pkg::COORD_W-1:0] length,
    input  logic                                color,
    input  logic [mfld_pkg::RIDX_W-1:0]         read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          read_data,
    output logic                                drawn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_data
);

    localparam int CW     = mfld_pkg::CW;
    localparam int RAW_W  = mfld_pkg::RAW_W;
    localparam int ADDR_W = mfld_pkg::ADDR_W;

    // sequencer states
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_START   = 4'd2;
    localparam logic [3:0] ST_END     = 4'd3;
    localparam logic [3:0] ST_CHECK   = 4'd4;
    localparam logic [3:0] ST_MAP_LO  = 4'd5;
    localparam logic [3:0] ST_MAP_HI  = 4'd6;
    localparam logic [3:0] ST_MAP_FIX = 4'd7;
    localparam logic [3:0] ST_INDEX   = 4'd8;
    localparam logic [3:0] ST_RUN     = 4'd9;
    localparam logic [3:0] ST_READ    = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [1:0]        rot_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              out_valid_reg;

    // request and working registers
    logic [1:0]              func_reg;
    logic signed [CW-1:0]    s0_reg;     // start on the run axis
    logic signed [CW-1:0]    f_reg;      // fixed coordinate
    logic signed [CW-1:0]    len_reg;
    logic                    color_reg;
    logic [mfld_pkg::RIDX_W-1:0] ridx_reg;
    logic signed [CW-1:0]    start_reg;
    logic signed [CW-1:0]    end_reg;
    logic [RAW_W-1:0]        lo_reg, hi_reg, fraw_reg;
    logic [RAW_W-1:0]        rlo_reg, rhi_reg, rf_reg;
    logic [RAW_W-1:0]        cur_reg, last_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic                    drawn_reg;
    logic [7:0]              out_data_reg;
    logic                    out_drawn_reg;

    // combinational
    logic                 accept;
    logic                 horiz;
    logic                 axis_x;     // raw run goes along raw x
    logic                 x_refl, y_refl, run_refl, fix_refl;
    logic                 neg_len;
    logic signed [CW-1:0] run_end, run_max, fix_end, fix_max;
    logic signed [CW-1:0] lo_clip, hi_clip;
    logic                 reject;
    logic [RAW_W-1:0]     rx_first, ry_first;
    logic [ADDR_W-1:0]    row_base;
    logic [7:0]           lo_mask, hi_mask, run_mask;
    logic                 in_range;
    logic                 out_load;

    mfld_pkg::alu_op_t    alu_op;
    logic [CW-1:0]        alu_sum;
    mfld_pkg::store_cmd_t st_cmd;
    logic [7:0]           st_rd_data;

    mfld_alu u_alu (
        .op  (alu_op),
        .sum (alu_sum)
    );

    mfld_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (st_cmd),
        .rd_data (st_rd_data)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign drawn     = out_drawn_reg;

    // rotation decode: raw x mirrors for quarter turns 1 and 2, raw y for 2 and 3
    assign horiz    = (func_reg != mfld_pkg::FUNC_VLINE);
    assign axis_x   = horiz ^ rot_reg[0];
    assign x_refl   = (rot_reg == 2'd1) || (rot_reg == 2'd2);
    assign y_refl   = (rot_reg == 2'd2) || (rot_reg == 2'd3);
    assign run_refl = axis_x ? x_refl : y_refl;
    assign fix_refl = axis_x ? y_refl : x_refl;
    assign neg_len  = len_reg[CW-1];

    // logical canvas extents follow the raw axis that each logical axis lands on
    assign run_end = axis_x ? CW'(mfld_pkg::PANEL_WIDTH)      : CW'(mfld_pkg::PANEL_HEIGHT);
    assign run_max = axis_x ? CW'(mfld_pkg::PANEL_WIDTH - 1)  : CW'(mfld_pkg::PANEL_HEIGHT - 1);
    assign fix_end = axis_x ? CW'(mfld_pkg::PANEL_HEIGHT)     : CW'(mfld_pkg::PANEL_WIDTH);
    assign fix_max = axis_x ? CW'(mfld_pkg::PANEL_HEIGHT - 1) : CW'(mfld_pkg::PANEL_WIDTH - 1);

    // reject and clip
    assign reject  = (f_reg < 0) || (f_reg >= fix_end) || (start_reg >= run_end)
                   || (end_reg < 0);
    assign lo_clip = (start_reg < 0) ? '0 : start_reg;
    assign hi_clip = (end_reg >= run_end) ? run_max : end_reg;

    // first store byte of the raw run
    assign rx_first = axis_x ? rlo_reg : rf_reg;
    assign ry_first = axis_x ? rf_reg  : rlo_reg;
    assign row_base = ADDR_W'(ry_first) * ADDR_W'(mfld_pkg::ROW_BYTES);

    // partial first and last byte masks along raw x, one bit along raw y
    assign lo_mask  = (cur_reg == (rlo_reg >> 3)) ? (mfld_pkg::BYTE_ALL >> rlo_reg[2:0])
                                                  : mfld_pkg::BYTE_ALL;
    assign hi_mask  = (cur_reg == (rhi_reg >> 3))
                    ? (mfld_pkg::BYTE_ALL << (3'd7 - rhi_reg[2:0]))
                    : mfld_pkg::BYTE_ALL;
    assign run_mask = axis_x ? (lo_mask & hi_mask) : (mfld_pkg::PIX_LEFT >> rf_reg[2:0]);

    assign in_range = ({1'b0, ridx_reg} < (mfld_pkg::RIDX_W + 1)'(mfld_pkg::STORE_BYTES));
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // shared adder operand selection
    always_comb
    begin
        alu_op = '0;
        unique case (state_reg)
            ST_START:
            begin
                alu_op.a   = s0_reg;
                alu_op.b   = neg_len ? len_reg : '0;
                alu_op.inc = neg_len;
            end
            ST_END:
            begin
                alu_op.a   = s0_reg;
                alu_op.b   = neg_len ? '0 : len_reg;
                alu_op.dec = !neg_len;
            end
            ST_MAP_LO:
            begin
                alu_op.a     = run_refl ? run_max : '0;
                alu_op.b     = CW'(run_refl ? hi_reg : lo_reg);
                alu_op.neg_b = run_refl;
            end
            ST_MAP_HI:
            begin
                alu_op.a     = run_refl ? run_max : '0;
                alu_op.b     = CW'(run_refl ? lo_reg : hi_reg);
                alu_op.neg_b = run_refl;
            end
            ST_MAP_FIX:
            begin
                alu_op.a     = fix_refl ? fix_max : '0;
                alu_op.b     = CW'(fraw_reg);
                alu_op.neg_b = fix_refl;
            end
            ST_INDEX:
            begin
                alu_op.a = CW'(row_base);
                alu_op.b = CW'(rx_first >> 3);
            end
            ST_RUN:
            begin
                alu_op.a = CW'(idx_reg);
                alu_op.b = axis_x ? CW'(1) : CW'(mfld_pkg::ROW_BYTES);
            end
            default:
            begin
                alu_op = '0;
            end
        endcase
    end

    // store requests
    always_comb
    begin
        st_cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                st_cmd.req  = 1'b1;
                st_cmd.wipe = 1'b1;
                st_cmd.addr = clr_cnt_reg;
            end
            ST_RUN:
            begin
                st_cmd.req  = 1'b1;
                st_cmd.set  = color_reg;
                st_cmd.addr = idx_reg;
                st_cmd.mask = run_mask;
            end
            ST_READ:
            begin
                // empty mask: the write-back leaves the byte as it is
                st_cmd.req  = in_range;
                st_cmd.addr = ridx_reg[ADDR_W-1:0];
                st_cmd.mask = mfld_pkg::BYTE_NONE;
            end
            default:
            begin
                st_cmd = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(mfld_pkg::STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (func == mfld_pkg::FUNC_READ) ? ST_READ : ST_START;
                end
            end
            ST_START:   state_next = ST_END;
            ST_END:     state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (reject || (lo_clip > hi_clip))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MAP_LO;
                end
            end
            ST_MAP_LO:  state_next = ST_MAP_HI;
            ST_MAP_HI:  state_next = ST_MAP_FIX;
            ST_MAP_FIX: state_next = ST_INDEX;
            ST_INDEX:   state_next = ST_RUN;
            ST_RUN:
            begin
                if (cur_reg == last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rot_reg       <= 2'd0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                rot_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            s0_reg    <= (func == mfld_pkg::FUNC_VLINE) ? CW'(y_coord) : CW'(x_coord);
            f_reg     <= (func == mfld_pkg::FUNC_VLINE) ? CW'(x_coord) : CW'(y_coord);
            // a single pixel is a line of one
            len_reg   <= (func == mfld_pkg::FUNC_PIXEL) ? CW'(1) : CW'(length);
            color_reg <= color;
            ridx_reg  <= read_index;
            drawn_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_START:
            begin
                start_reg <= alu_sum;
            end
            ST_END:
            begin
                end_reg <= alu_sum;
            end
            ST_CHECK:
            begin
                lo_reg   <= lo_clip[RAW_W-1:0];
                hi_reg   <= hi_clip[RAW_W-1:0];
                fraw_reg <= f_reg[RAW_W-1:0];
            end
            ST_MAP_LO:
            begin
                rlo_reg <= alu_sum[RAW_W-1:0];
            end
            ST_MAP_HI:
            begin
                rhi_reg <= alu_sum[RAW_W-1:0];
            end
            ST_MAP_FIX:
            begin
                rf_reg <= alu_sum[RAW_W-1:0];
            end
            ST_INDEX:
            begin
                idx_reg  <= alu_sum[ADDR_W-1:0];
                cur_reg  <= axis_x ? (rlo_reg >> 3) : rlo_reg;
                last_reg <= axis_x ? (rhi_reg >> 3) : rhi_reg;
            end
            ST_RUN:
            begin
                idx_reg <= alu_sum[ADDR_W-1:0];
                cur_reg <= cur_reg + 1'b1;
                if (cur_reg == last_reg)
                begin
                    drawn_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg  <= ((func_reg == mfld_pkg::FUNC_READ) && in_range)
                           ? st_rd_data : mfld_pkg::BYTE_NONE;
            out_drawn_reg <= drawn_reg;
        end
    end

`ifndef SYNTHESIS
    // a result either reports drawn pixels or carries read data, never both
    a_drawn_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && drawn) |-> (read_data == mfld_pkg::BYTE_NONE))
        else $error("drawn result carries read data");

    // byte walk stays inside its clipped span
    a_run_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> ((cur_reg <= last_reg) && (rlo_reg <= rhi_reg)))
        else $error("run walked past its last byte");

    // every drawing access lands inside the store
    a_run_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg < ADDR_W'(mfld_pkg::STORE_BYTES)))
        else $error("store address out of range");

    // no request is taken while the clearing pass runs
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request accepted during clearing pass");
`endif

endmodule

// ----- test/mono_framebuffer_line_draw_core_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// mono_framebuffer_line_draw_core_checker
// Watches the request, result and config channels of the line drawer, keeps a
// shadow framebuffer under the current rotation and compares every result.
// ============================================================================
module mono_framebuffer_line_draw_core_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic signed [mfld_pkg::COORD_W-1:0] x_coord,
    input  logic signed [mfld_pkg::COORD_W-1:0] y_coord,
    input  logic signed [mfld_pkg::COORD_W-1:0] length,
    input  logic                                color,
    input  logic [mfld_pkg::RIDX_W-1:0]         read_index,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [7:0]                          read_data,
    input  logic                                drawn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [1:0]                          cfg_data,
    output int                                  error_count,
    output int                                  pending_count
);

    localparam int PANEL_WIDTH  = mfld_pkg::PANEL_WIDTH;
    localparam int PANEL_HEIGHT = mfld_pkg::PANEL_HEIGHT;
    localparam int ROW_BYTES    = mfld_pkg::ROW_BYTES;
    localparam int STORE_BYTES  = mfld_pkg::STORE_BYTES;

    localparam logic [1:0] TURN_NONE          = 2'd0;
    localparam logic [1:0] TURN_QUARTER       = 2'd1;
    localparam logic [1:0] TURN_HALF          = 2'd2;
    localparam logic [1:0] TURN_THREE_QUARTER = 2'd3;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drawn;
    } frame_result_t;

    logic [7:0]    shadow_frame [STORE_BYTES];
    logic [1:0]    turns;
    frame_result_t awaited_results [$];

    // one logical pixel through the rotation; 1 when it lands on the panel
    function automatic bit paint_pixel(int lx, int ly, bit set);
        int rx;
        int ry;
        int idx;
        case (turns)
            TURN_QUARTER:
            begin
                rx = PANEL_WIDTH - 1 - ly;
                ry = lx;
            end
            TURN_HALF:
            begin
                rx = PANEL_WIDTH - 1 - lx;
                ry = PANEL_HEIGHT - 1 - ly;
            end
            TURN_THREE_QUARTER:
            begin
                rx = ly;
                ry = PANEL_HEIGHT - 1 - lx;
            end
            default:
            begin
                rx = lx;
                ry = ly;
            end
        endcase
        if (rx < 0 || rx >= PANEL_WIDTH || ry < 0 || ry >= PANEL_HEIGHT)
            return 1'b0;
        idx = (rx >> 3) + ry * ROW_BYTES;
        if (set)
            shadow_frame[idx] = shadow_frame[idx] | (mfld_pkg::PIX_LEFT >> rx[2:0]);
        else
            shadow_frame[idx] = shadow_frame[idx] & ~(mfld_pkg::PIX_LEFT >> rx[2:0]);
        return 1'b1;
    endfunction

    // clipped run; s on the run axis, f the fixed coordinate
    function automatic bit paint_run(bit along_x, int s, int f, int len,
                                     int run_end, int fix_end, bit set);
        bit any;
        any = 1'b0;
        if (len < 0)
        begin
            len = -len;
            s   = s - (len - 1);
            if (s < 0)
            begin
                len = len + s;
                s   = 0;
            end
        end
        if (f < 0 || f >= fix_end || s >= run_end || (s + len - 1) < 0)
            return 1'b0;
        if (s < 0)
        begin
            len = len + s;
            s   = 0;
        end
        if (s + len > run_end)
            len = run_end - s;
        for (int i = 0; i < len; i++)
        begin
            if (along_x)
                any |= paint_pixel(s + i, f, set);
            else
                any |= paint_pixel(f, s + i, set);
        end
        return any;
    endfunction

    function automatic frame_result_t apply_request(logic [1:0] op, int x, int y, int len,
                                                    bit set, int ridx);
        frame_result_t r;
        int            canvas_w;
        int            canvas_h;
        canvas_w    = turns[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        canvas_h    = turns[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        r.read_data = mfld_pkg::BYTE_NONE;
        r.drawn     = 1'b0;
        case (op)
            mfld_pkg::FUNC_PIXEL:
                r.drawn = paint_pixel(x, y, set);
            mfld_pkg::FUNC_HLINE:
                r.drawn = paint_run(1'b1, x, y, len, canvas_w, canvas_h, set);
            mfld_pkg::FUNC_VLINE:
                r.drawn = paint_run(1'b0, y, x, len, canvas_h, canvas_w, set);
            default:
            begin
                if (ridx < STORE_BYTES)
                    r.read_data = shadow_frame[ridx];
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t got;
        frame_result_t want;
        if (!rst_n)
        begin
            foreach (shadow_frame[i])
                shadow_frame[i] = mfld_pkg::BYTE_NONE;
            turns = TURN_NONE;
            awaited_results.delete();
            error_count   = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.read_data = read_data;
                got.drawn     = drawn;
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result read_data %02h drawn %0b",
                             $time, got.read_data, got.drawn);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        error_count++;
                        $display("%0t: read_data expected %02h actual %02h",
                                 $time, want.read_data, got.read_data);
                    end
                    if (got.drawn !== want.drawn)
                    begin
                        error_count++;
                        $display("%0t: drawn expected %0b actual %0b",
                                 $time, want.drawn, got.drawn);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                turns = cfg_data;
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(func, int'(x_coord), int'(y_coord),
                                                        int'(length), color,
                                                        int'(read_index)));
            pending_count = awaited_results.size();
        end
    end

endmodule

// ----- test/mono_framebuffer_line_draw_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// mono_framebuffer_line_draw_core_tb
// Drives pixel, line and read-back requests into the line drawer under all
// four rotations, with bursty requests and a stalling result side; the
// checker beside the block predicts and compares every result.
// ============================================================================
module mono_framebuffer_line_draw_core_tb;

    localparam int COORD_W      = mfld_pkg::COORD_W;
    localparam int RIDX_W       = mfld_pkg::RIDX_W;
    localparam int PANEL_WIDTH  = mfld_pkg::PANEL_WIDTH;
    localparam int PANEL_HEIGHT = mfld_pkg::PANEL_HEIGHT;
    localparam int ROW_BYTES    = mfld_pkg::ROW_BYTES;
    localparam int STORE_BYTES  = mfld_pkg::STORE_BYTES;

    // random requests per rotation phase, five phases
    localparam int PHASE_REQS = 260;
    // long result hold-off, well beyond one full-column line
    localparam int LONG_HOLD = 1500;
    // tail wait after the last result, above the longest line
    localparam int SETTLE_CYCLES = 300;
    // slowest run is about 1300 requests plus the clearing pass and the stalls; take it several times over
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] len;
        logic               color;
        logic [RIDX_W-1:0]  ridx;
    } draw_req_t;

    typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 func;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [COORD_W-1:0]  length;
    logic                       color;
    logic [RIDX_W-1:0]          read_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [7:0]                 read_data;
    logic                       drawn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_data;

    int        error_count;
    int        pending_count;
    int        cycle_count = 0;
    bit        hold_kick;
    int        phase_turns [5] = '{1, 3, 2, 0, 3};
    draw_req_t directed_reqs [$];

    mono_framebuffer_line_draw_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .length     (length),
        .color      (color),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .drawn      (drawn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    mono_framebuffer_line_draw_core_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .length        (length),
        .color         (color),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .drawn         (drawn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("mono_framebuffer_line_draw_core_tb: errors");
            $finish;
        end
    end

    // result side: stretches of always ready, coin flip and sparse ready;
    // a toggle of hold_kick starts one long hold-off counted here
    initial
    begin : result_sink
        int          hold_left;
        int          stretch;
        bit          last_kick;
        ready_mode_t mode;
        out_ready = 1'b0;
        hold_left = 0;
        stretch   = 0;
        last_kick = 1'b0;
        mode      = READY_ALWAYS;
        forever
        begin
            @(negedge clk);
            if (hold_kick != last_kick)
            begin
                last_kick = hold_kick;
                hold_left = LONG_HOLD;
            end
            if (stretch == 0)
            begin
                mode    = ready_mode_t'($urandom_range(0, 2));
                stretch = $urandom_range(4, 60);
            end
            stretch--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    READY_ALWAYS: out_ready = 1'b1;
                    READY_COIN:   out_ready = $urandom_range(0, 1);
                    default:      out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic draw_req_t make_req(logic [1:0] f, int x, int y, int len,
                                           bit c, int ridx);
        draw_req_t r;
        r.func  = f;
        r.x     = COORD_W'(x);
        r.y     = COORD_W'(y);
        r.len   = COORD_W'(len);
        r.color = c;
        r.ridx  = RIDX_W'(ridx);
        return r;
    endfunction

    // mostly near the canvas, some on its borders, a few anywhere in 16 bits
    function automatic int pick_coord();
        int c;
        int p;
        p = $urandom_range(0, 99);
        if (p < 80)
            c = int'($urandom_range(0, 270)) - 35;
        else if (p < 90)
        begin
            case ($urandom_range(0, 3))
                0:       c = -1;
                1:       c = 0;
                2:       c = PANEL_WIDTH - 1;
                default: c = PANEL_WIDTH;
            endcase
        end
        else
            c = int'($urandom_range(0, 65535)) - 32768;
        return c;
    endfunction

    function automatic draw_req_t random_request();
        logic [1:0] f;
        int         len;
        int         ridx;
        int         p;
        p = $urandom_range(0, 99);
        if (p < 25)
            f = mfld_pkg::FUNC_READ;
        else if (p < 45)
            f = mfld_pkg::FUNC_PIXEL;
        else if (p < 72)
            f = mfld_pkg::FUNC_HLINE;
        else
            f = mfld_pkg::FUNC_VLINE;
        p = $urandom_range(0, 99);
        if (p < 55)
            len = int'($urandom_range(0, 520)) - 260;
        else if (p < 80)
            len = int'($urandom_range(0, 16)) - 8;
        else
            len = int'($urandom_range(0, 65535)) - 32768;
        // reads mostly inside the store, some around its end, some anywhere
        p = $urandom_range(0, 99);
        if (p < 70)
            ridx = $urandom_range(0, STORE_BYTES - 1);
        else if (p < 85)
            ridx = $urandom_range(STORE_BYTES - 100, STORE_BYTES + 100);
        else
            ridx = $urandom_range(0, (1 << RIDX_W) - 1);
        return make_req(f, pick_coord(), pick_coord(), len, $urandom_range(0, 1), ridx);
    endfunction

    // present one request and hold it until taken; returns at the next falling edge
    task automatic offer(input draw_req_t r);
        in_valid   = 1'b1;
        func       = r.func;
        x_coord    = r.x;
        y_coord    = r.y;
        length     = r.len;
        color      = r.color;
        read_index = r.ridx;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_all_results();
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // rotation changes only with no result outstanding
    task automatic set_rotation(input logic [1:0] quarter_turns);
        wait_all_results();
        cfg_valid = 1'b1;
        cfg_data  = quarter_turns;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int  sent;
        int  burst;
        int  gap;
        bit  held;
        bit  paused;

        // every block input known from time zero
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = mfld_pkg::FUNC_READ;
        x_coord    = '0;
        y_coord    = '0;
        length     = '0;
        color      = 1'b0;
        read_index = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        hold_kick  = 1'b0;
        held       = 1'b0;
        paused     = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the write lands during the clearing pass that follows reset
        set_rotation(2'd0);

        // directed requests, unrotated
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0,
                                         STORE_BYTES - 1));
        // read past the store end
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0,
                                         (1 << RIDX_W) - 1));
        // opposite corner pixels and their bytes
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, 0, 0, 0, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, PANEL_WIDTH - 1,
                                         PANEL_HEIGHT - 1, 0, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0,
                                         STORE_BYTES - 1));
        // off-panel pixels are dropped
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, -1, 5, 0, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, PANEL_WIDTH, 0, 0, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, -32768, 32767, 0, 1'b1, 0));
        // run with partial first and last byte masks
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, 3, 1, 10, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0, ROW_BYTES));
        // negative length that overshoots below zero
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, 20, 2, -30, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0,
                                         2 * ROW_BYTES + 2));
        // zero length draws nothing
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, 5, 3, 0, 1'b1, 0));
        // last pixel still left of the canvas: rejected
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, -32768, 3, 32767, 1'b1, 0));
        // huge run clipped to the whole row
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, -100, 4, 32767, 1'b1, 0));
        // fixed row off the canvas: rejected
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, 0, PANEL_HEIGHT, 10,
                                         1'b1, 0));
        // start at the canvas end, negative length pulls it back in
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_HLINE, PANEL_WIDTH, 5, -5, 1'b1, 0));
        // full column, clipped at both ends
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_VLINE, 7, -5, 300, 1'b1, 0));
        // clear part of it going upward
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_VLINE, 7, 10, -5, 1'b0, 0));
        // most negative length from the top coordinate
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_VLINE, 0, 32767, -32768, 1'b1, 0));
        // fixed column off the canvas: rejected
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_VLINE, -1, 0, 10, 1'b1, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_PIXEL, 0, 0, 0, 1'b0, 0));
        directed_reqs.push_back(make_req(mfld_pkg::FUNC_READ, 0, 0, 0, 1'b0,
                                         6 * ROW_BYTES));
        foreach (directed_reqs[i])
            offer(directed_reqs[i]);

        // random requests, one phase per rotation setting
        foreach (phase_turns[p])
        begin
            set_rotation(phase_turns[p][1:0]);
            sent = 0;
            while (sent < PHASE_REQS)
            begin
                // long result hold-off while requests keep coming
                if (p == 1 && !held && sent >= 40)
                begin
                    hold_kick = ~hold_kick;
                    held      = 1'b1;
                end
                // one full pause until the block has drained
                if (p == 3 && !paused && sent >= 120)
                begin
                    wait_all_results();
                    paused = 1'b1;
                end
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && sent < PHASE_REQS; k++)
                begin
                    offer(random_request());
                    sent++;
                end
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
                if (gap > 0)
                begin
                    in_valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("mono_framebuffer_line_draw_core_tb: clean");
        else
            $display("mono_framebuffer_line_draw_core_tb: errors");
        $finish;
    end

endmodule
